// ----- hw/rtl/mlfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfd_pkg
// shared constants and the result item type of the marker/length deframer
// ----------------------------------------------------------------------------
package mlfd_pkg;

	// start marker bytes
	localparam logic [7:0] MARK_FIRST  = 8'h50;
	localparam logic [7:0] MARK_SECOND = 8'h42;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// widths
	localparam int LEN_W = 31;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       first_of_frame;
		logic       last_of_frame;
	} res_t;

endpackage

// ----- hw/rtl/marker_length_frame_deframer_core.sv -----
// ----------------------------------------------------------------------------
// marker_length_frame_deframer_core
// one byte per cycle while the queue has room; a result is held in the queue,
// then in the output register, and the front takes new bytes meanwhile
// in_ready drops only when the four-entry result queue is full
// reset clears the hunt state and the queue, and max_length returns to all ones
// ----------------------------------------------------------------------------
module marker_length_frame_deframer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// byte stream in
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	// configuration write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mlfd_pkg::LEN_W-1:0]  cfg_data,
	// result items out
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [7:0]                  data_byte,
	output logic                        first_of_frame,
	output logic                        last_of_frame
);

	logic [mlfd_pkg::LEN_W-1:0] max_length_q;

	logic           acc;
	logic           push;
	mlfd_pkg::res_t push_item;
	logic           pop;
	mlfd_pkg::res_t head_item;
	logic           not_empty;
	logic           full;
	mlfd_pkg::res_t out_item;

	// a byte makes at most one result, so one free queue slot is enough
	assign in_ready  = !full;
	assign acc       = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// maximum length register, consulted on the fourth length byte only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= '1;
		end else if (cfg_valid) begin
			max_length_q <= cfg_data;
		end
	end

	// front: marker hunt, length gather, payload counting
	mlfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.in_byte    (in_byte),
		.max_length (max_length_q),
		.push       (push),
		.push_item  (push_item)
	);

	// queue lets the front keep taking bytes while the output stalls
	mlfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.not_empty (not_empty),
		.full      (full)
	);

	// back: registered output stage
	mlfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head_item (head_item),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	assign kind           = out_item.kind;
	assign data_byte      = out_item.data_byte;
	assign first_of_frame = out_item.first_of_frame;
	assign last_of_frame  = out_item.last_of_frame;

endmodule

// ----- hw/rtl/mlfd_front.sv -----
// ----------------------------------------------------------------------------
// mlfd_front
// marker hunt, length gather and payload count; classifies each byte
// ----------------------------------------------------------------------------
module mlfd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  logic [7:0]                  in_byte,
	input  logic [mlfd_pkg::LEN_W-1:0]  max_length,
	output logic                        push,
	output mlfd_pkg::res_t              push_item
);

	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_GOT_P = 2'd1;
	localparam logic [1:0] PH_LEN   = 2'd2;
	localparam logic [1:0] PH_DATA  = 2'd3;

	localparam logic [1:0] LEN_LAST = 2'd3;

	logic [1:0]                 phase_q;
	logic [1:0]                 len_cnt_q;
	logic [23:0]                gather_q;
	logic [mlfd_pkg::LEN_W-1:0] remaining_q;
	logic                       first_q;

	logic [31:0] full_len;
	logic        too_long;
	logic        is_zero;
	logic        last_byte;

	assign full_len  = {in_byte, gather_q};
	assign too_long  = full_len > {1'b0, max_length};
	assign is_zero   = (full_len == 32'd0);
	assign last_byte = (remaining_q[mlfd_pkg::LEN_W-1:1] == '0);

	// result decode for the byte on the input
	always_comb begin
		push      = 1'b0;
		push_item = '{kind: mlfd_pkg::KIND_DATA, data_byte: 8'd0,
			first_of_frame: 1'b0, last_of_frame: 1'b0};
		unique case (phase_q)
			PH_LEN: begin
				if (len_cnt_q == LEN_LAST) begin
					if (too_long) begin
						push = acc;
						push_item.kind = mlfd_pkg::KIND_ERROR;
						push_item.last_of_frame = 1'b1;
					end else if (is_zero) begin
						push = acc;
						push_item.kind = mlfd_pkg::KIND_EMPTY;
						push_item.last_of_frame = 1'b1;
					end
				end
			end
			PH_DATA: begin
				push = acc;
				push_item.data_byte = in_byte;
				push_item.first_of_frame = first_q;
				push_item.last_of_frame = last_byte;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			len_cnt_q   <= 2'd0;
			remaining_q <= '0;
			first_q     <= 1'b0;
		end else if (acc) begin
			unique case (phase_q)
				PH_HUNT: begin
					phase_q <= (in_byte == mlfd_pkg::MARK_FIRST) ? PH_GOT_P : PH_HUNT;
				end
				PH_GOT_P: begin
					if (in_byte == mlfd_pkg::MARK_SECOND) begin
						phase_q   <= PH_LEN;
						len_cnt_q <= 2'd0;
					end else if (in_byte != mlfd_pkg::MARK_FIRST) begin
						phase_q <= PH_HUNT;
					end
				end
				PH_LEN: begin
					if (len_cnt_q != LEN_LAST) begin
						len_cnt_q <= len_cnt_q + 2'd1;
					end else begin
						len_cnt_q <= 2'd0;
						if (too_long || is_zero) begin
							phase_q <= PH_HUNT;
						end else begin
							remaining_q <= full_len[mlfd_pkg::LEN_W-1:0];
							first_q     <= 1'b1;
							phase_q     <= PH_DATA;
						end
					end
				end
				PH_DATA: begin
					first_q <= 1'b0;
					if (last_byte) begin
						remaining_q <= '0;
						phase_q     <= PH_HUNT;
					end else begin
						remaining_q <= remaining_q - 31'd1;
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	// low three length bytes, little-endian
	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_GOT_P && in_byte == mlfd_pkg::MARK_SECOND) begin
			gather_q <= '0;
		end else if (acc && phase_q == PH_LEN) begin
			case (len_cnt_q)
				2'd0:    gather_q[7:0]   <= in_byte;
				2'd1:    gather_q[15:8]  <= in_byte;
				2'd2:    gather_q[23:16] <= in_byte;
				default: gather_q        <= gather_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/mlfd_queue.sv -----
// ----------------------------------------------------------------------------
// mlfd_queue
// short result queue between the front and the back
// ----------------------------------------------------------------------------
module mlfd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mlfd_pkg::res_t push_item,
	input  logic           pop,
	output mlfd_pkg::res_t head_item,
	output logic           not_empty,
	output logic           full
);

	mlfd_pkg::res_t mem_q [mlfd_pkg::QUEUE_DEPTH];

	logic [mlfd_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [mlfd_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [mlfd_pkg::QUEUE_AW:0]   count_q;

	assign full      = (count_q == (mlfd_pkg::QUEUE_AW+1)'(mlfd_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/mlfd_back.sv -----
// ----------------------------------------------------------------------------
// mlfd_back
// output register stage: takes items from the queue and presents them
// ----------------------------------------------------------------------------
module mlfd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           not_empty,
	input  mlfd_pkg::res_t head_item,
	output logic           pop,
	input  logic           out_ready,
	output logic           out_valid,
	output mlfd_pkg::res_t out_item
);

	logic           out_valid_q;
	mlfd_pkg::res_t out_item_q;

	assign pop       = not_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q <= head_item;
		end
	end

endmodule
